/* src/csp_pkg.sv */
// ============================================================================
// csp_pkg
// Shared types and constants for the circuit support property checker.
// ============================================================================
package csp_pkg;

    localparam int NODE_AW = 10;   // node index width, 1024 nodes
    localparam int SUP_W   = 64;   // support bitset width, one bit per variable
    localparam int KIND_W  = 3;
    localparam int LIT_W   = 7;
    localparam int CNT_W   = 11;
    localparam int VIOL_W  = 16;
    localparam int ADDR_W  = 4;

    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [VIOL_W-1:0] VIOL_ONE = VIOL_W'(1);

    localparam logic [KIND_W-1:0] KIND_TRUE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FALSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LEAF  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_AND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OR    = 3'd4;

    localparam logic [1:0] REG_DEC_EN    = 2'd0;
    localparam logic [1:0] REG_SMOOTH_EN = 2'd1;
    localparam logic [1:0] REG_VIOL_CAP  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // command to the per-node accumulator
    typedef struct packed {
        logic step;
        logic first;
        logic add_and;
        logic add_or;
    } t_acc_cmd;

    // status of the node after the current item
    typedef struct packed {
        logic failed;
        logic multi;
    } t_acc_stat;

endpackage

/* src/csp_ram.sv */
// ============================================================================
// csp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module csp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/csp_node_acc.sv */
// ============================================================================
// csp_node_acc
// Per-node accumulator: running support union, first child support and
// the failure flag of the node under construction.
// ============================================================================
module csp_node_acc (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  csp_pkg::t_acc_cmd        i_cmd,
    input  logic [csp_pkg::SUP_W-1:0] i_child_sup,
    output logic [csp_pkg::SUP_W-1:0] o_union,
    output csp_pkg::t_acc_stat       o_stat
);

    logic [csp_pkg::SUP_W-1:0] r_union, n_union;
    logic [csp_pkg::SUP_W-1:0] r_first, n_first;
    logic                      r_fail, n_fail;
    logic [1:0]                r_kids, n_kids;

    logic [csp_pkg::SUP_W-1:0] b_union, b_first;
    logic                      b_fail;
    logic [1:0]                b_kids;

    always_comb begin
        // first item of a node starts from empty state
        b_union = i_cmd.first ? '0 : r_union;
        b_first = i_cmd.first ? '0 : r_first;
        b_fail  = i_cmd.first ? 1'b0 : r_fail;
        b_kids  = i_cmd.first ? 2'd0 : r_kids;

        n_union = b_union;
        n_first = b_first;
        n_fail  = b_fail;
        n_kids  = b_kids;

        if (i_cmd.add_and) begin
            if (|(b_union & i_child_sup)) begin
                n_fail = 1'b1;
            end
        end
        if (i_cmd.add_or) begin
            if (b_kids == 2'd0) begin
                n_first = i_child_sup;
            end else if (i_child_sup != b_first) begin
                n_fail = 1'b1;
            end
        end
        if (i_cmd.add_and || i_cmd.add_or) begin
            n_union = b_union | i_child_sup;
            if (b_kids != 2'd2) begin
                n_kids = b_kids + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_union <= '0;
            r_first <= '0;
            r_fail  <= 1'b0;
            r_kids  <= 2'd0;
        end else if (i_cmd.step) begin
            r_union <= n_union;
            r_first <= n_first;
            r_fail  <= n_fail;
            r_kids  <= n_kids;
        end
    end

    assign o_union       = n_union;
    assign o_stat.failed = n_fail;
    assign o_stat.multi  = (n_kids == 2'd2);

endmodule

/* src/circuit_support_property_checker_core.sv */
// ============================================================================
// circuit_support_property_checker_core
// Decomposability and smoothness checker for a circuit streamed bottom-up.
// ============================================================================
// Items arrive one per child edge of an AND/OR node, or one per leaf or
// constant. An accepted item issues a read of its child's support from a
// 1024 x 64 support memory; in the next cycle the child support is merged
// into the node's running union and checked (AND: overlap with the union of
// earlier children, OR: equality with the first child). On the last item of
// a node the node's support is written back at its index and one result
// item is loaded into the output register. A write and a read of the same
// entry on one edge are resolved by forwarding the written support. The
// block takes one item per cycle as long as results are taken; an item is
// held in the execute stage only while a finished result still waits in the
// output register. The result is registered: the memory read is registered
// at the accept edge, and the merge/check runs in the execute stage and ends
// in the result register when that stage finishes.
// Configuration: the decomposability check enable at 0x0, the smoothness
// check enable at 0x4 and the violation cap at 0x8 on the APB port. Support
// entries are undefined until their node has been completed once.
// ============================================================================
module circuit_support_property_checker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [csp_pkg::NODE_AW-1:0]   i_node_id,
    input  logic [csp_pkg::KIND_W-1:0]    i_node_kind,
    input  logic [csp_pkg::LIT_W-1:0]     i_literal,
    input  logic [csp_pkg::NODE_AW-1:0]   i_child_id,
    input  logic                          i_child_present,
    input  logic                          i_first_child,
    input  logic                          i_last_child,
    // result item channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [csp_pkg::NODE_AW-1:0]   o_done_node,
    output logic                          o_decomp_fail,
    output logic                          o_smooth_fail,
    output logic                          o_reported,
    output logic [csp_pkg::CNT_W-1:0]     o_and_total,
    output logic [csp_pkg::CNT_W-1:0]     o_or_total,
    output logic                          o_all_decomposable,
    output logic                          o_all_smooth,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                        r_cfg_dec;
    logic                        r_cfg_smooth;
    logic [csp_pkg::VIOL_W-1:0]  r_cfg_cap;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dec    <= 1'b1;
            r_cfg_smooth <= 1'b1;
            r_cfg_cap    <= 16'd16;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                csp_pkg::REG_DEC_EN:    r_cfg_dec    <= pwdata[0];
                csp_pkg::REG_SMOOTH_EN: r_cfg_smooth <= pwdata[0];
                csp_pkg::REG_VIOL_CAP:  r_cfg_cap    <= pwdata[csp_pkg::VIOL_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            csp_pkg::REG_DEC_EN:    prdata = {31'd0, r_cfg_dec};
            csp_pkg::REG_SMOOTH_EN: prdata = {31'd0, r_cfg_smooth};
            csp_pkg::REG_VIOL_CAP:  prdata = {16'd0, r_cfg_cap};
            default:                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // item held in the execute stage
    // ------------------------------------------------------------------
    logic [csp_pkg::NODE_AW-1:0] r_node_id;
    logic [csp_pkg::KIND_W-1:0]  r_kind;
    logic [csp_pkg::LIT_W-1:0]   r_literal;
    logic                        r_has_child;
    logic                        r_first;
    logic                        r_last;

    // ------------------------------------------------------------------
    // control: idle / execute
    // ------------------------------------------------------------------
    csp_pkg::t_state r_state, n_state;
    logic            exec_done;
    logic            in_acc;
    logic            r_ov;

    // execute stage finishes unless its result would overwrite a waiting one
    assign exec_done  = (r_state == csp_pkg::ST_EXEC) && (!r_last || !r_ov || i_out_ready);
    assign o_in_ready = (r_state == csp_pkg::ST_IDLE) || exec_done;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csp_pkg::ST_IDLE: begin
                if (in_acc) n_state = csp_pkg::ST_EXEC;
            end
            csp_pkg::ST_EXEC: begin
                if (exec_done && !in_acc) n_state = csp_pkg::ST_IDLE;
            end
            default: n_state = csp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_node_id   <= i_node_id;
            r_kind      <= i_node_kind;
            r_literal   <= i_literal;
            r_has_child <= i_child_present;
            r_first     <= i_first_child;
            r_last      <= i_last_child;
        end
    end

    // ------------------------------------------------------------------
    // support memory with write-to-read forwarding
    // ------------------------------------------------------------------
    logic                        mem_we;
    logic [csp_pkg::SUP_W-1:0]   mem_wdata;
    logic [csp_pkg::SUP_W-1:0]   mem_rdata;
    logic                        r_fwd_hit;
    logic [csp_pkg::SUP_W-1:0]   r_fwd_data;
    logic [csp_pkg::SUP_W-1:0]   child_sup;

    assign mem_we = exec_done && r_last;

    csp_ram #(
        .WIDTH (csp_pkg::SUP_W),
        .DEPTH (1 << csp_pkg::NODE_AW)
    ) u_support_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_node_id),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (i_child_id),
        .o_rdata (mem_rdata)
    );

    // capture a same-edge write to the entry being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_acc) begin
            r_fwd_hit <= mem_we && (r_node_id == i_child_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= mem_wdata;
        end
    end

    assign child_sup = r_fwd_hit ? r_fwd_data : mem_rdata;

    // ------------------------------------------------------------------
    // per-node accumulation and checks
    // ------------------------------------------------------------------
    logic                        is_and, is_or, is_leaf;
    csp_pkg::t_acc_cmd           acc_cmd;
    csp_pkg::t_acc_stat          acc_stat;
    logic [csp_pkg::SUP_W-1:0]   acc_union;

    assign is_and  = (r_kind == csp_pkg::KIND_AND);
    assign is_or   = (r_kind == csp_pkg::KIND_OR);
    assign is_leaf = (r_kind == csp_pkg::KIND_LEAF);

    assign acc_cmd.step    = exec_done;
    assign acc_cmd.first   = r_first;
    assign acc_cmd.add_and = r_has_child && is_and;
    assign acc_cmd.add_or  = r_has_child && is_or;

    csp_node_acc u_node_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (acc_cmd),
        .i_child_sup (child_sup),
        .o_union     (acc_union),
        .o_stat      (acc_stat)
    );

    // support written back for the completed node; constants stay empty
    always_comb begin
        if (is_leaf) begin
            mem_wdata = {{(csp_pkg::SUP_W-1){1'b0}}, 1'b1} << r_literal[csp_pkg::LIT_W-1:1];
        end else if (is_and || is_or) begin
            mem_wdata = acc_union;
        end else begin
            mem_wdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // completion: counters, pass flags, result register
    // ------------------------------------------------------------------
    logic [csp_pkg::CNT_W-1:0]   r_and_cnt, r_or_cnt;
    logic [csp_pkg::VIOL_W-1:0]  r_viol_cnt;
    logic [1:0]                  r_pass;
    logic                        dfail, sfail, rep;

    assign dfail = acc_stat.failed && acc_stat.multi && is_and && r_cfg_dec;
    assign sfail = acc_stat.failed && acc_stat.multi && is_or && r_cfg_smooth;
    assign rep   = (dfail || sfail) && (r_viol_cnt < r_cfg_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_and_cnt  <= '0;
            r_or_cnt   <= '0;
            r_viol_cnt <= '0;
            r_pass     <= 2'b11;
        end else if (mem_we) begin
            // saturate all counters at their maximum
            if (is_and && (r_and_cnt != '1)) r_and_cnt <= r_and_cnt + csp_pkg::CNT_ONE;
            if (is_or && (r_or_cnt != '1))   r_or_cnt  <= r_or_cnt + csp_pkg::CNT_ONE;
            if (dfail) r_pass[0] <= 1'b0;
            if (sfail) r_pass[1] <= 1'b0;
            if ((dfail || sfail) && (r_viol_cnt != '1)) begin
                r_viol_cnt <= r_viol_cnt + csp_pkg::VIOL_ONE;
            end
        end
    end

    logic [csp_pkg::NODE_AW-1:0] r_done_node;
    logic                        r_dfail, r_sfail, r_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (mem_we) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_done_node <= r_node_id;
            r_dfail     <= dfail;
            r_sfail     <= sfail;
            r_rep       <= rep;
        end
    end

    // running totals and pass flags change only when a result is loaded
    assign o_out_valid        = r_ov;
    assign o_done_node        = r_done_node;
    assign o_decomp_fail      = r_dfail;
    assign o_smooth_fail      = r_sfail;
    assign o_reported         = r_rep;
    assign o_and_total        = r_and_cnt;
    assign o_or_total         = r_or_cnt;
    assign o_all_decomposable = r_pass[0];
    assign o_all_smooth       = r_pass[1];

endmodule

/* src/csp_checker.sv */
// ============================================================================
// csp_checker
// Port-level checks on the result channel of the support property checker.
// ============================================================================
module csp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [csp_pkg::NODE_AW-1:0] o_done_node,
    input logic                        o_decomp_fail,
    input logic                        o_smooth_fail,
    input logic                        o_reported,
    input logic                        o_all_decomposable,
    input logic                        o_all_smooth
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_done_node))
        else $error("result changed while stalled");

    // pass flag drops only together with a failing result of that kind
    a_dec_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_all_decomposable) |-> o_out_valid && o_decomp_fail)
        else $error("decomposable flag fell without a failing result");

    a_fail_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_smooth_fail |-> !o_all_smooth && !o_decomp_fail)
        else $error("smooth failure inconsistent with flags");

    // only a failing node can be reported
    a_rep_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reported |-> o_decomp_fail || o_smooth_fail)
        else $error("reported without a violation");

endmodule

bind circuit_support_property_checker_core csp_checker u_csp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_done_node        (o_done_node),
    .o_decomp_fail      (o_decomp_fail),
    .o_smooth_fail      (o_smooth_fail),
    .o_reported         (o_reported),
    .o_all_decomposable (o_all_decomposable),
    .o_all_smooth       (o_all_smooth)
);
